[hw/rtl/tcadc_pkg.sv]
// Shared types, constants and curve tables for the thermocouple linearizer.
`timescale 1ns / 1ps

package tcadc_pkg;

    // Field widths.
    localparam int RAW_W    = 15;
    localparam int HANDLE_W = 11;
    localparam int TEMP_W   = 10;
    localparam int OFFSET_W = 14;

    // Internal widths: microvolts, working word, narrow operand, table index.
    localparam int UV_W     = 22;
    localparam int WORD_W   = 32;
    localparam int OPB_W    = 16;
    localparam int IDX_W    = 6;
    localparam int ROM_SIZE = 51;

    // Handle tenths to whole degrees by reciprocal multiplication.
    localparam int HQ_W        = 8;
    localparam int DIV10_SHIFT = 16;
    localparam int HPROD_W     = HANDLE_W + 13;
    localparam logic [HPROD_W-1:0] DIV10_RECIP = HPROD_W'(6554);

    // Scaling constants.
    localparam logic [OPB_W-1:0] ADC_SCALE  = OPB_W'(33000);
    localparam int               ADC_SHIFT  = 15;            // 4096 * 8 counts
    localparam logic [OPB_W-1:0] MV_TO_UV   = OPB_W'(100);
    localparam logic [OPB_W-1:0] FRAC_SCALE = OPB_W'(1000);

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(900);
    localparam logic [TEMP_W-1:0]   TEMP_MAX     = TEMP_W'(1023);

    // Serial unit step counts (two bits per cycle).
    localparam int MUL_STEPS = OPB_W / 2;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_STEPS = WORD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ADC,
        ST_MUL_MV,
        ST_DIV_GAIN,
        ST_WALK,
        ST_MUL_DX,
        ST_DIV_DX,
        ST_MUL_DY,
        ST_DIV_K,
        ST_SUM,
        ST_DONE
    } seq_state_t;

    // Request and response of a serial arithmetic unit.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [OPB_W-1:0]  b;
    } op_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } op_resp_t;

    // Finished temperature offered by the sequencer.
    typedef struct packed {
        logic              valid;
        logic [TEMP_W-1:0] temp;
    } temp_res_t;

    // Microvolt breakpoints of the thermocouple curve.
    localparam logic [OPB_W-1:0] CURVE_X0 [ROM_SIZE] = '{
        16'd0,     16'd266,   16'd522,   16'd770,   16'd1010,
        16'd1244,  16'd1473,  16'd1697,  16'd1917,  16'd2135,
        16'd2351,  16'd2566,  16'd2780,  16'd2994,  16'd3209,
        16'd3426,  16'd3644,  16'd3865,  16'd4088,  16'd4314,
        16'd4544,  16'd4777,  16'd5014,  16'd5255,  16'd5500,
        16'd5750,  16'd6003,  16'd6261,  16'd6523,  16'd6789,
        16'd7059,  16'd7332,  16'd7609,  16'd7889,  16'd8171,
        16'd8456,  16'd8742,  16'd9030,  16'd9319,  16'd9607,
        16'd9896,  16'd10183, 16'd10468, 16'd10750, 16'd11029,
        16'd11304, 16'd11573, 16'd11835, 16'd12091, 16'd12337,
        16'd12575
    };

    // Microvolt breakpoints of the linear curve.
    localparam logic [OPB_W-1:0] CURVE_X1 [ROM_SIZE] = '{
        16'd530,   16'd1282,  16'd2034,  16'd2786,  16'd3538,
        16'd4290,  16'd5043,  16'd5795,  16'd6547,  16'd7299,
        16'd8051,  16'd8803,  16'd9555,  16'd10308, 16'd11060,
        16'd11812, 16'd12564, 16'd13316, 16'd14068, 16'd14820,
        16'd15573, 16'd16325, 16'd17077, 16'd17829, 16'd18581,
        16'd19333, 16'd20085, 16'd20838, 16'd21590, 16'd22342,
        16'd23094, 16'd23846, 16'd24598, 16'd25350, 16'd26103,
        16'd26855, 16'd27607, 16'd28359, 16'd29111, 16'd29863,
        16'd30615, 16'd31368, 16'd32120, 16'd32872, 16'd33624,
        16'd34376, 16'd35128, 16'd35880, 16'd36632, 16'd37385,
        16'd38137
    };

    // Temperatures of the breakpoints; both curves share the same steps.
    localparam logic [TEMP_W-1:0] CURVE_Y [ROM_SIZE] = '{
        10'd0,   10'd10,  10'd20,  10'd30,  10'd40,
        10'd50,  10'd60,  10'd70,  10'd80,  10'd90,
        10'd100, 10'd110, 10'd120, 10'd130, 10'd140,
        10'd150, 10'd160, 10'd170, 10'd180, 10'd190,
        10'd200, 10'd210, 10'd220, 10'd230, 10'd240,
        10'd250, 10'd260, 10'd270, 10'd280, 10'd290,
        10'd300, 10'd310, 10'd320, 10'd330, 10'd340,
        10'd350, 10'd360, 10'd370, 10'd380, 10'd390,
        10'd400, 10'd410, 10'd420, 10'd430, 10'd440,
        10'd450, 10'd460, 10'd470, 10'd480, 10'd490,
        10'd500
    };

    // Breakpoint voltage of the selected curve.
    function automatic logic [OPB_W-1:0] rom_x(input logic sel, input logic [IDX_W-1:0] idx);
        logic [OPB_W-1:0] val;
        if (idx > IDX_W'(ROM_SIZE - 1))
        begin
            val = '0;
        end
        else if (sel)
        begin
            val = CURVE_X1[idx];
        end
        else
        begin
            val = CURVE_X0[idx];
        end
        return val;
    endfunction

    // Breakpoint temperature.
    function automatic logic [TEMP_W-1:0] rom_y(input logic [IDX_W-1:0] idx);
        logic [TEMP_W-1:0] val;
        if (idx > IDX_W'(ROM_SIZE - 1))
        begin
            val = '0;
        end
        else
        begin
            val = CURVE_Y[idx];
        end
        return val;
    endfunction

    // Two's complement from magnitude and sign, wrapping at the word width.
    function automatic logic [WORD_W-1:0] apply_sign(input logic [WORD_W-1:0] mag,
                                                     input logic neg);
        return neg ? (~mag + WORD_W'(1)) : mag;
    endfunction

    // Magnitude of a two's complement word.
    function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] val);
        return val[WORD_W-1] ? (~val + WORD_W'(1)) : val;
    endfunction

endpackage

[hw/rtl/tcadc_mul.sv]
// Serial shift-add multiplier, two multiplier bits per cycle, product modulo 2^32.
`timescale 1ns / 1ps

module tcadc_mul
    import tcadc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  op_req_t  req,
    output op_resp_t resp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    mcand_reg, mcand_next;
    logic [OPB_W-1:0]     mplier_reg, mplier_next;
    logic [WORD_W-1:0]    acc_reg, acc_next;
    logic [WORD_W-1:0]    partial;

    // Partial product of the current two-bit digit.
    always_comb
    begin
        partial = (mplier_reg[0] ? mcand_reg : '0)
                + (mplier_reg[1] ? {mcand_reg[WORD_W-2:0], 1'b0} : '0);
    end

    // Load on start, then accumulate one digit per cycle.
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (!busy_reg && req.start)
        begin
            busy_next   = 1'b1;
            cnt_next    = MUL_CNT_W'(MUL_STEPS - 1);
            mcand_next  = req.a;
            mplier_next = req.b;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            acc_next    = acc_reg + partial;
            mcand_next  = {mcand_reg[WORD_W-3:0], 2'b00};
            mplier_next = {2'b00, mplier_reg[OPB_W-1:2]};
            cnt_next    = cnt_reg - MUL_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign resp.done   = done_reg;
    assign resp.result = acc_reg;

endmodule

[hw/rtl/tcadc_div.sv]
// Serial restoring divider, two quotient bits per cycle, 32-bit dividend by 16-bit divisor.
`timescale 1ns / 1ps

module tcadc_div
    import tcadc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  op_req_t  req,
    output op_resp_t resp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OPB_W-1:0]     rem_reg, rem_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [OPB_W-1:0]     dvsr_reg, dvsr_next;
    logic [OPB_W:0]       trial1, trial2, red1, red2;
    logic                 ge1, ge2;

    // Two restoring steps: the dividend shifts out on top, quotient bits shift in below.
    always_comb
    begin
        trial1 = {rem_reg, quo_reg[WORD_W-1]};
        ge1    = trial1 >= {1'b0, dvsr_reg};
        red1   = ge1 ? (trial1 - {1'b0, dvsr_reg}) : trial1;
        trial2 = {red1[OPB_W-1:0], quo_reg[WORD_W-2]};
        ge2    = trial2 >= {1'b0, dvsr_reg};
        red2   = ge2 ? (trial2 - {1'b0, dvsr_reg}) : trial2;
    end

    // Load on start, then iterate.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (!busy_reg && req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = req.a;
            dvsr_next = req.b;
        end
        else if (busy_reg)
        begin
            rem_next = red2[OPB_W-1:0];
            quo_next = {quo_reg[WORD_W-3:0], ge1, ge2};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Remainder, quotient and divisor registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign resp.done   = done_reg;
    assign resp.result = quo_reg;

endmodule

[hw/rtl/tcadc_seq.sv]
// Sequencer: scaling, curve walk and interpolation over the shared serial units.
`timescale 1ns / 1ps

module tcadc_seq
    import tcadc_pkg::*;
#(
    parameter int AMP_GAIN     = 317,
    parameter int TABLE_POINTS = 51,
    parameter int TABLE_SELECT = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RAW_W-1:0]    raw_adc,
    input  logic [HANDLE_W-1:0] handle_temp_tenths,
    input  logic                sample_enable,
    input  logic [OFFSET_W-1:0] offset,
    input  logic                slot_free,
    output logic                idle,
    output temp_res_t           res
);

    localparam int USED_POINTS = (TABLE_POINTS < 2) ? 2 :
                                 ((TABLE_POINTS > ROM_SIZE) ? ROM_SIZE : TABLE_POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(USED_POINTS - 1);
    localparam logic             CURVE_SEL = (TABLE_SELECT != 0);
    localparam logic [OPB_W-1:0] GAIN_DIV  = OPB_W'((AMP_GAIN < 1) ? 1 : AMP_GAIN);

    seq_state_t state_reg, state_next;
    logic       launch_reg, launch_next;

    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [HQ_W-1:0]   handle_q_reg, handle_q_next;
    logic [WORD_W-1:0] work_reg, work_next;
    logic              neg_reg, neg_next;
    logic [UV_W-1:0]   uv_reg, uv_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              zero_reg, zero_next;
    logic [TEMP_W-1:0] held_reg, held_next;

    op_req_t  mul_req, div_req;
    op_resp_t mul_resp, div_resp;

    logic [HPROD_W-1:0] hprod;
    logic [IDX_W-1:0]   idx_lo;
    logic [OPB_W-1:0]   x_lo, x_hi;
    logic [TEMP_W-1:0]  y_lo, y_hi;
    logic [OPB_W:0]     dx;
    logic               dx_neg, dx_zero;
    logic [OPB_W-1:0]   dx_mag;
    logic [TEMP_W:0]    dy;
    logic               dy_neg;
    logic [OPB_W-1:0]   dy_mag;
    logic [WORD_W-1:0]  diff;
    logic               walk_stop;
    logic [UV_W-1:0]    quot_uv, off_uv, uv_calc;
    logic [WORD_W-1:0]  signed_res, mul_signed, t_sum;
    logic [TEMP_W-1:0]  t_clamp;
    logic               is_mul, is_div;

    tcadc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .resp  (mul_resp)
    );

    tcadc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // Bracketing pair of the curve at the walk index.
    always_comb
    begin
        idx_lo    = idx_reg - IDX_W'(1);
        x_lo      = rom_x(CURVE_SEL, idx_lo);
        x_hi      = rom_x(CURVE_SEL, idx_reg);
        y_lo      = rom_y(idx_lo);
        y_hi      = rom_y(idx_reg);
        dx        = {1'b0, x_hi} - {1'b0, x_lo};
        dx_neg    = dx[OPB_W];
        dx_zero   = (dx == '0);
        dx_mag    = dx_neg ? OPB_W'(-dx) : dx[OPB_W-1:0];
        dy        = {1'b0, y_hi} - {1'b0, y_lo};
        dy_neg    = dy[TEMP_W];
        dy_mag    = OPB_W'(dy_neg ? (-dy) : dy);
        diff      = WORD_W'(uv_reg) - WORD_W'(x_lo);
        walk_stop = (idx_reg >= LAST_IDX) || (uv_reg < UV_W'(x_hi));
    end

    // Microvolts after the offset, floored at zero.
    always_comb
    begin
        quot_uv = div_resp.result[UV_W-1:0];
        off_uv  = UV_W'(offset);
        uv_calc = (quot_uv >= off_uv) ? (quot_uv - off_uv) : '0;
    end

    // Handle tenths to whole degrees, and the final sum with clamping.
    always_comb
    begin
        hprod      = HPROD_W'(handle_temp_tenths) * DIV10_RECIP;
        signed_res = apply_sign(div_resp.result, neg_reg);
        mul_signed = apply_sign(mul_resp.result, neg_reg);
        t_sum      = (zero_reg ? '0 : WORD_W'(y_lo)) + work_reg + WORD_W'(handle_q_reg);
        if (t_sum[WORD_W-1])
        begin
            t_clamp = '0;
        end
        else if (t_sum > WORD_W'(TEMP_MAX))
        begin
            t_clamp = TEMP_MAX;
        end
        else
        begin
            t_clamp = t_sum[TEMP_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sample_enable ? ST_MUL_ADC : ST_DONE;
                end
            end
            ST_MUL_ADC:
            begin
                if (mul_resp.done)
                begin
                    state_next = ST_MUL_MV;
                end
            end
            ST_MUL_MV:
            begin
                if (mul_resp.done)
                begin
                    state_next = ST_DIV_GAIN;
                end
            end
            ST_DIV_GAIN:
            begin
                if (div_resp.done)
                begin
                    state_next = (uv_calc == '0) ? ST_SUM : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_stop)
                begin
                    state_next = dx_zero ? ST_SUM : ST_MUL_DX;
                end
            end
            ST_MUL_DX:
            begin
                if (mul_resp.done)
                begin
                    state_next = ST_DIV_DX;
                end
            end
            ST_DIV_DX:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_MUL_DY;
                end
            end
            ST_MUL_DY:
            begin
                if (mul_resp.done)
                begin
                    state_next = ST_DIV_K;
                end
            end
            ST_DIV_K:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        launch_next = (state_next != state_reg);
    end

    // Outputs: unit requests, operand selection and handshake.
    always_comb
    begin
        is_mul    = 1'b0;
        is_div    = 1'b0;
        mul_req.a = work_reg;
        mul_req.b = FRAC_SCALE;
        div_req.a = work_reg;
        div_req.b = FRAC_SCALE;
        unique case (state_reg)
            ST_MUL_ADC:
            begin
                is_mul    = 1'b1;
                mul_req.a = WORD_W'(raw_reg);
                mul_req.b = ADC_SCALE;
            end
            ST_MUL_MV:
            begin
                is_mul    = 1'b1;
                mul_req.b = MV_TO_UV;
            end
            ST_DIV_GAIN:
            begin
                is_div    = 1'b1;
                div_req.b = GAIN_DIV;
            end
            ST_MUL_DX:
            begin
                is_mul = 1'b1;
            end
            ST_DIV_DX:
            begin
                is_div    = 1'b1;
                div_req.b = dx_mag;
            end
            ST_MUL_DY:
            begin
                is_mul    = 1'b1;
                mul_req.b = dy_mag;
            end
            ST_DIV_K:
            begin
                is_div = 1'b1;
            end
            default:
            begin
                is_mul = 1'b0;
                is_div = 1'b0;
            end
        endcase
        mul_req.start = launch_reg && is_mul;
        div_req.start = launch_reg && is_div;
        idle          = (state_reg == ST_IDLE);
        res.valid     = (state_reg == ST_DONE);
        res.temp      = held_reg;
    end

    // Datapath next values.
    always_comb
    begin
        raw_next      = raw_reg;
        handle_q_next = handle_q_reg;
        work_next     = work_reg;
        neg_next      = neg_reg;
        uv_next       = uv_reg;
        idx_next      = idx_reg;
        zero_next     = zero_reg;
        held_next     = held_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    raw_next      = raw_adc;
                    handle_q_next = hprod[DIV10_SHIFT +: HQ_W];
                    zero_next     = 1'b0;
                end
            end
            ST_MUL_ADC:
            begin
                if (mul_resp.done)
                begin
                    work_next = mul_resp.result >> ADC_SHIFT;
                end
            end
            ST_MUL_MV:
            begin
                if (mul_resp.done)
                begin
                    work_next = mul_resp.result;
                end
            end
            ST_DIV_GAIN:
            begin
                if (div_resp.done)
                begin
                    uv_next   = uv_calc;
                    zero_next = (uv_calc == '0);
                    work_next = '0;
                    idx_next  = IDX_W'(1);
                end
            end
            ST_WALK:
            begin
                if (!walk_stop)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                else if (dx_zero)
                begin
                    work_next = '0;
                end
                else
                begin
                    work_next = abs_word(diff);
                    neg_next  = diff[WORD_W-1];
                end
            end
            ST_MUL_DX:
            begin
                if (mul_resp.done)
                begin
                    work_next = abs_word(mul_signed);
                    neg_next  = mul_signed[WORD_W-1] ^ dx_neg;
                end
            end
            ST_DIV_DX:
            begin
                if (div_resp.done)
                begin
                    work_next = abs_word(signed_res);
                    neg_next  = signed_res[WORD_W-1] ^ dy_neg;
                end
            end
            ST_MUL_DY:
            begin
                if (mul_resp.done)
                begin
                    work_next = abs_word(mul_signed);
                    neg_next  = mul_signed[WORD_W-1];
                end
            end
            ST_DIV_K:
            begin
                if (div_resp.done)
                begin
                    work_next = signed_res;
                end
            end
            ST_SUM:
            begin
                held_next = t_clamp;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    // Control state and held temperature.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            held_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            held_reg   <= held_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        handle_q_reg <= handle_q_next;
        work_reg     <= work_next;
        neg_reg      <= neg_next;
        uv_reg       <= uv_next;
        idx_reg      <= idx_next;
        zero_reg     <= zero_next;
    end

endmodule

[hw/rtl/thermocouple_adc_to_celsius.sv]
// Top level: configuration register, output register and the linearization sequencer.
`timescale 1ns / 1ps

// Converts one oversampled thermocouple ADC sample plus the handle temperature
// into a tip temperature in whole degrees Celsius.
// Input channel: in_valid/in_ready with raw_adc, handle_temp_tenths and
// sample_enable. Output channel: out_valid/out_ready with tip_temp_c, one
// result per accepted input. Configuration: cfg_valid/cfg_ready with the
// calibration offset in microvolts; cfg_ready is always high, and the user must
// write the offset only while no sample is in flight; the block does not enforce it.
// A disabled sample returns the held temperature, and an enabled sample whose
// voltage comes out as zero skips the curve walk and interpolation. Any other
// enabled sample makes four passes through the two-bit-per-cycle multiplier,
// three passes through the two-bit-per-cycle divider and walks the curve one
// point per cycle.
// One sample is processed at a time; in_ready is high only while the sequencer
// is idle. The output register holds a finished result while out_ready is low,
// and the next sample is accepted in the meantime; its result waits until the
// register frees up. Reset clears the held temperature to 0, the offset to
// 900 uV and empties the output register.

module thermocouple_adc_to_celsius
    import tcadc_pkg::*;
#(
    parameter int AMP_GAIN     = 317,
    parameter int TABLE_POINTS = 51,
    parameter int TABLE_SELECT = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [RAW_W-1:0]    raw_adc,
    input  logic [HANDLE_W-1:0] handle_temp_tenths,
    input  logic                sample_enable,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TEMP_W-1:0]   tip_temp_c,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [OFFSET_W-1:0] calibration_offset_uv
);

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                out_valid_reg, out_valid_next;
    logic [TEMP_W-1:0]   tip_reg, tip_next;
    logic                seq_idle, slot_free, in_xfer;
    temp_res_t           seq_res;

    tcadc_seq #(
        .AMP_GAIN     (AMP_GAIN),
        .TABLE_POINTS (TABLE_POINTS),
        .TABLE_SELECT (TABLE_SELECT)
    ) u_seq (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (in_xfer),
        .raw_adc            (raw_adc),
        .handle_temp_tenths (handle_temp_tenths),
        .sample_enable      (sample_enable),
        .offset             (offset_reg),
        .slot_free          (slot_free),
        .idle               (seq_idle),
        .res                (seq_res)
    );

    // Handshake glue.
    assign in_ready  = seq_idle;
    assign in_xfer   = in_valid && seq_idle;
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || out_ready;

    // Offset register takes every configuration transfer.
    always_comb
    begin
        offset_next = cfg_valid ? calibration_offset_uv : offset_reg;
    end

    // Output register: load a finished result when free, drop it on transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        tip_next       = tip_reg;
        if (seq_res.valid && slot_free)
        begin
            out_valid_next = 1'b1;
            tip_next       = seq_res.temp;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= OFFSET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tip_reg <= tip_next;
    end

    assign out_valid  = out_valid_reg;
    assign tip_temp_c = tip_reg;

endmodule

[hw/rtl/tcadc_checker.sv]
// Port-level checker for the thermocouple linearizer, bound to the top level.
`timescale 1ns / 1ps

module tcadc_checker
    import tcadc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                sample_enable,
    input logic                out_valid,
    input logic                out_ready,
    input logic [TEMP_W-1:0]   tip_temp_c,
    input logic                cfg_valid,
    input logic                cfg_ready
);

    // A stalled result stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(tip_temp_c)))
        else $error("stalled result changed or dropped");

    // One sample at a time: input is closed right after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input open in the cycle after a transfer");

    // No result appears in the cycle right after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared too early");

    // A disabled sample still yields a result, through the done state, when the output is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !sample_enable && !out_valid) |=> ##1 out_valid)
        else $error("held temperature not returned");

    // The configuration port never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transfer stalled");

endmodule

bind thermocouple_adc_to_celsius tcadc_checker u_tcadc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_enable (sample_enable),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tip_temp_c    (tip_temp_c),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
